// File: rtl/idct_pkg.sv
`timescale 1ns / 1ps

package idct_pkg;

  localparam int N = 8;

  typedef logic [N-1:0][15:0] row_t;

  typedef enum logic [1:0] {
    S_ROWS,
    S_COL,
    S_WAIT
  } state_t;

  // Control for the column lanes, one stage apart.
  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic first;
  } col_ctl_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] k;
    logic [2:0] i;
  } col_pipe_t;

  // 64-scaled DCT basis, indexed [k][n].
  localparam logic signed [7:0] BASIS [N][N] = '{
    '{8'sd64,  8'sd64,  8'sd64,  8'sd64,  8'sd64,  8'sd64,  8'sd64,  8'sd64},
    '{8'sd89,  8'sd75,  8'sd50,  8'sd18, -8'sd18, -8'sd50, -8'sd75, -8'sd89},
    '{8'sd83,  8'sd36, -8'sd36, -8'sd83, -8'sd83, -8'sd36,  8'sd36,  8'sd83},
    '{8'sd75, -8'sd18, -8'sd89, -8'sd50,  8'sd50,  8'sd89,  8'sd18, -8'sd75},
    '{8'sd64, -8'sd64, -8'sd64,  8'sd64,  8'sd64, -8'sd64, -8'sd64,  8'sd64},
    '{8'sd50, -8'sd89,  8'sd18,  8'sd75, -8'sd75, -8'sd18,  8'sd89, -8'sd50},
    '{8'sd36, -8'sd83,  8'sd83, -8'sd36, -8'sd36,  8'sd83, -8'sd83,  8'sd36},
    '{8'sd18, -8'sd50,  8'sd75, -8'sd89,  8'sd89, -8'sd75,  8'sd50, -8'sd18}
  };

endpackage

// File: rtl/idct_row_lane.sv
`timescale 1ns / 1ps

module idct_row_lane import idct_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [2:0]  col,
  input  row_t        coef,
  output logic [15:0] result
);

  logic signed [23:0] prod [N];
  logic signed [26:0] sum;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        prod[k] <= $signed(coef[k]) * BASIS[k][col];
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < N; k++) begin
      sum = sum + 27'(prod[k]);
    end
  end

  // floor shift by 6, keep 16 bits
  assign result = sum[21:6];

endmodule

// File: rtl/idct_store.sv
`timescale 1ns / 1ps

module idct_store import idct_pkg::*; (
  input  logic       clk,
  input  logic       wr_en,
  input  logic [2:0] wr_addr,
  input  row_t       wr_data,
  input  logic       rd_en,
  input  logic [2:0] rd_addr,
  output row_t       rd_data
);

  row_t mem [N];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/idct_col_lane.sv
`timescale 1ns / 1ps

module idct_col_lane import idct_pkg::*; (
  input  logic              clk,
  input  col_ctl_t          ctl,
  input  logic signed [7:0] coef,
  input  logic [15:0]       data,
  output logic [7:0]        pix
);

  logic signed [23:0] prod;
  logic signed [25:0] acc;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= coef * $signed(data);
    end
    if (ctl.acc_en) begin
      acc <= ctl.first ? 26'(prod) : acc + 26'(prod);
    end
  end

  // floor shift by 12, clamp to 0..255
  always_comb begin
    if (acc[25]) begin
      pix = 8'd0;
    end else if (|acc[24:20]) begin
      pix = 8'd255;
    end else begin
      pix = acc[19:12];
    end
  end

endmodule

// File: rtl/idct_8x8_integer_block.sv
`timescale 1ns / 1ps

// Rows go in one per cycle while in_stall is low; a taken row is registered as lane
// products and then written into the transpose store. After the eighth row, the column pass
// reads one store row per cycle, eight reads per pixel row, through 8 MAC lanes; each pixel
// row then passes the multiply and accumulate registers into the output register, and the
// next pixel row starts once the lanes drain and the output slot is free, with input stalled
// throughout. Synchronous active-high reset clears control; the transpose store is not cleared.

module idct_8x8_integer_block import idct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] coef_0,
  input  logic [15:0] coef_1,
  input  logic [15:0] coef_2,
  input  logic [15:0] coef_3,
  input  logic [15:0] coef_4,
  input  logic [15:0] coef_5,
  input  logic [15:0] coef_6,
  input  logic [15:0] coef_7,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pix_0,
  output logic [7:0]  pix_1,
  output logic [7:0]  pix_2,
  output logic [7:0]  pix_3,
  output logic [7:0]  pix_4,
  output logic [7:0]  pix_5,
  output logic [7:0]  pix_6,
  output logic [7:0]  pix_7,
  output logic [2:0]  row_index,
  output logic        last_row
);

  state_t     state, state_next;
  logic [2:0] row_cnt;
  logic [2:0] col_k;
  logic [2:0] col_i;
  logic       rd_en;
  logic       in_acc;
  logic       out_acc;

  logic       row_v1;
  logic [2:0] row_r1;
  row_t       coef_row;
  row_t       wr_data;
  row_t       rd_data;

  col_pipe_t  p1, p2, p3;
  col_ctl_t   ctl;
  logic [7:0] lane_pix [N];
  logic [7:0] pix [N];

  assign coef_row = {coef_7, coef_6, coef_5, coef_4, coef_3, coef_2, coef_1, coef_0};
  assign in_stall = (state != S_ROWS);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  for (genvar g = 0; g < N; g++) begin : g_row
    idct_row_lane u_row (
      .clk    (clk),
      .en     (in_acc),
      .col    (3'(g)),
      .coef   (coef_row),
      .result (wr_data[g])
    );
  end

  idct_store u_store (
    .clk     (clk),
    .wr_en   (row_v1),
    .wr_addr (row_r1),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (col_k),
    .rd_data (rd_data)
  );

  assign ctl.mul_en = p1.valid;
  assign ctl.acc_en = p2.valid;
  assign ctl.first  = (p2.k == 3'd0);

  for (genvar g = 0; g < N; g++) begin : g_col
    idct_col_lane u_col (
      .clk  (clk),
      .ctl  (ctl),
      .coef (BASIS[p1.k][p1.i]),
      .data (rd_data[g]),
      .pix  (lane_pix[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ROWS;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    case (state)
      S_ROWS: begin
        if (in_acc && row_cnt == 3'd7) begin
          state_next = S_COL;
        end
      end
      S_COL: begin
        rd_en = 1'b1;
        if (col_k == 3'd7) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        // hold until the lanes drain and the output slot is free
        if (!p1.valid && !p2.valid && !p3.valid && (!out_valid || !out_stall)) begin
          state_next = (col_i == 3'd0) ? S_ROWS : S_COL;
        end
      end
      default: state_next = S_ROWS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_k   <= '0;
      col_i   <= '0;
      row_v1  <= 1'b0;
      p1      <= '0;
      p2      <= '0;
      p3      <= '0;
    end else begin
      row_v1 <= in_acc;
      if (in_acc) begin
        row_cnt <= row_cnt + 3'd1;
      end
      if (rd_en) begin
        col_k <= col_k + 3'd1;
        if (col_k == 3'd7) begin
          col_i <= col_i + 3'd1;
        end
      end
      p1.valid <= rd_en;
      p1.k     <= col_k;
      p1.i     <= col_i;
      p2       <= p1;
      p3.valid <= p2.valid && (p2.k == 3'd7);
      p3.k     <= p2.k;
      p3.i     <= p2.i;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_r1 <= row_cnt;
    end
  end

  // merge the lanes into one output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p3.valid) begin
      out_valid <= 1'b1;
    end else if (out_acc) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p3.valid) begin
      pix       <= lane_pix;
      row_index <= p3.i;
      last_row  <= (p3.i == 3'd7);
    end
  end

  assign pix_0 = pix[0];
  assign pix_1 = pix[1];
  assign pix_2 = pix[2];
  assign pix_3 = pix[3];
  assign pix_4 = pix[4];
  assign pix_5 = pix[5];
  assign pix_6 = pix[6];
  assign pix_7 = pix[7];

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    p3.valid |-> !out_valid)
    else $error("result landed on an occupied output register");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (row_v1 && rd_en) |-> (col_k != row_r1))
    else $error("column read hit the row being written");

  a_last_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_row == (row_index == 3'd7)))
    else $error("last_row does not match row_index");

  a_reopen_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_acc && last_row) |=> !in_stall)
    else $error("input not reopened after the last pixel row");

endmodule
